// ===== design/eog_pkg.sv =====
`default_nettype none
package eog_pkg;

  localparam int unsigned NUM_REGS = 8;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Z    = 3'd1;
  localparam logic [2:0] REG_SEMI_MAJOR  = 3'd2;
  localparam logic [2:0] REG_SEMI_MINOR  = 3'd3;
  localparam logic [2:0] REG_TILT        = 3'd4;
  localparam logic [2:0] REG_SPEED       = 3'd5;
  localparam logic [2:0] REG_SPIN_BASE   = 3'd6;
  localparam logic [2:0] REG_SPIN_ENABLE = 3'd7;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21024;
  localparam logic [15:0] SIN_C = 16'd2320;

  typedef struct packed {
    logic        func;
    logic [15:0] phase_value;
    logic [15:0] time_delta;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]         node_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic [15:0]        spin_angle;
    logic               spin_valid;
    logic               last;
  } out_beat_t;

  // command handed from the front end to the back end
  typedef struct packed {
    logic        func;
    logic [15:0] phase_value;
    logic [15:0] step;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_z;
    logic [30:0]        semi_major;
    logic [30:0]        semi_minor;
    logic [15:0]        tilt;
    logic signed [23:0] speed;
    logic [15:0]        spin_base;
    logic               spin_enable;
  } cfg_t;

  // quarter-wave polynomial on one quadrant position, Q14 in, Q15 out
  function automatic logic [15:0] quarter_sin(input logic [14:0] x);
    logic [29:0] xx;
    logic [15:0] z2;
    logic [31:0] t1;
    logic [15:0] t;
    logic [31:0] t2;
    logic [15:0] u;
    logic [31:0] y;
    xx = {15'd0, x} * {15'd0, x};
    z2 = xx[29:14];
    t1 = {16'd0, SIN_C} * {16'd0, z2};
    t = SIN_B - t1[29:14];
    t2 = {16'd0, t} * {16'd0, z2};
    u = SIN_A - t2[29:14];
    y = {17'd0, x} * {16'd0, u} + 32'd8192;
    if (y[31:14] > 18'd32767) begin
      quarter_sin = 16'd32767;
    end else begin
      quarter_sin = y[29:14];
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/eog_trig.sv =====
`default_nettype none
// sequential sine unit: polynomial in several registered steps
module eog_trig (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [15:0]        angle,
  output logic                    done,
  output logic signed [15:0]      result
);
  typedef enum logic [5:0] {
    T_IDLE = 6'b000001, T_SQ = 6'b000010, T_P1 = 6'b000100,
    T_P2 = 6'b001000, T_P3 = 6'b010000, T_FIN = 6'b100000
  } tstate_t;

  tstate_t     state_r;
  logic [14:0] x_r;
  logic        neg_r;
  logic [15:0] z2_r;
  logic [31:0] prod_r;
  logic        done_r;
  logic signed [15:0] result_r;
  logic [13:0] r;
  logic [31:0] y;

  assign r = angle[13:0];
  assign y = prod_r + 32'd8192;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        T_IDLE: begin
          if (start) begin
            x_r   <= angle[14] ? (15'd16384 - {1'b0, r}) : {1'b0, r};
            neg_r <= angle[15];
            state_r <= T_SQ;
          end
        end
        T_SQ: begin
          prod_r  <= {17'd0, x_r} * {17'd0, x_r};
          state_r <= T_P1;
        end
        T_P1: begin
          z2_r    <= prod_r[29:14];
          prod_r  <= {16'd0, eog_pkg::SIN_C} * {16'd0, prod_r[29:14]};
          state_r <= T_P2;
        end
        T_P2: begin
          prod_r  <= {16'd0, eog_pkg::SIN_B - prod_r[29:14]} * {16'd0, z2_r};
          state_r <= T_P3;
        end
        T_P3: begin
          prod_r  <= {17'd0, x_r} * {16'd0, eog_pkg::SIN_A - prod_r[29:14]};
          state_r <= T_FIN;
        end
        T_FIN: begin
          if (y[31:14] > 18'd32767) begin
            result_r <= neg_r ? -16'sd32767 : 16'sd32767;
          end else begin
            result_r <= neg_r ? -$signed(y[29:14]) : $signed(y[29:14]);
          end
          done_r  <= 1'b1;
          state_r <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign result = result_r;
endmodule
`default_nettype wire

// ===== design/eog_front.sv =====
`default_nettype none
// accepts items, computes the tick phase step, pushes commands into the queue
module eog_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire eog_pkg::in_beat_t  in_data,
  input  wire logic signed [23:0] speed,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output eog_pkg::cmd_t           q_data
);
  localparam int unsigned QD = 2;

  eog_pkg::cmd_t mem_r [QD];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic signed [40:0] prod;
  eog_pkg::cmd_t cmd;
  logic push, pop;

  assign prod = speed * $signed({1'b0, in_data.time_delta}) + 41'sd32768;
  always_comb begin
    cmd.func        = in_data.func;
    cmd.phase_value = in_data.phase_value;
    cmd.step        = prod[31:16];
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

// ===== design/eog_back.sv =====
`default_nettype none
// stores loaded node phases; on a tick walks them and builds one result per node
module eog_back #(
  parameter int unsigned MAX_NODES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire eog_pkg::cmd_t      q_data,
  input  wire eog_pkg::cfg_t      cfg,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output eog_pkg::out_beat_t      out_data
);
  localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001, S_TCOS = 12'b000000000010,
    S_TSIN = 12'b000000000100, S_RD   = 12'b000000001000,
    S_PH   = 12'b000000010000, S_NCOS = 12'b000000100000,
    S_NSIN = 12'b000001000000, S_M1   = 12'b000010000000,
    S_M2   = 12'b000100000000, S_M3   = 12'b001000000000,
    S_M4   = 12'b010000000000, S_OUT  = 12'b100000000000
  } bstate_t;

  bstate_t state_r;
  logic [15:0] mem [MAX_NODES];
  logic [15:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] idx_r;
  logic [15:0] step_r, ph_r;
  logic signed [15:0] cphi_r, sphi_r, ct_r, st_r;
  logic signed [31:0] f_r [4];
  logic signed [63:0] acc_x_r, acc_z_r;
  logic [1:0] mi_r;
  logic trig_start, trig_done;
  logic [15:0] trig_angle;
  logic signed [15:0] trig_res;
  logic trig_busy_r;
  logic signed [63:0] mprod_r;
  logic out_valid_r;
  logic out_load;
  eog_pkg::out_beat_t out_r;
  logic signed [63:0] rx, rz;
  logic signed [34:0] sx, sz;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;

  eog_trig u_trig (
    .clk(clk), .rst_n(rst_n), .start(trig_start), .angle(trig_angle),
    .done(trig_done), .result(trig_res)
  );

  assign q_ready = (state_r == S_IDLE);

  // output register takes a new beat when empty or being drained
  assign out_load = (state_r == S_M4) && (!out_valid_r || out_ready);

  always_comb begin
    trig_start = 1'b0;
    trig_angle = cfg.tilt;
    if (!trig_busy_r) begin
      unique case (state_r)
        S_TCOS: begin trig_start = 1'b1; trig_angle = cfg.tilt + 16'd16384; end
        S_TSIN: begin trig_start = 1'b1; trig_angle = cfg.tilt; end
        S_NCOS: begin trig_start = 1'b1; trig_angle = ph_r + 16'd16384; end
        S_NSIN: begin trig_start = 1'b1; trig_angle = ph_r; end
        default: trig_start = 1'b0;
      endcase
    end
  end

  always_comb begin
    unique case (mi_r)
      2'd0: begin mul_a = {1'b0, cfg.semi_major}; mul_b = f_r[0]; end
      2'd1: begin mul_a = {1'b0, cfg.semi_minor}; mul_b = f_r[1]; end
      2'd2: begin mul_a = {1'b0, cfg.semi_major}; mul_b = f_r[2]; end
      default: begin mul_a = {1'b0, cfg.semi_minor}; mul_b = f_r[3]; end
    endcase
  end

  assign rx = acc_x_r + 64'sd536870912;
  assign rz = acc_z_r + 64'sd536870912;
  assign sx = 35'(rx >>> 30) + 35'(cfg.center_x);
  assign sz = 35'(rz >>> 30) + 35'(cfg.center_z);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid && q_data.func == eog_pkg::FUNC_LOAD &&
        cnt_r < CW'(MAX_NODES)) begin
      mem[cnt_r[IW-1:0]] <= q_data.phase_value;
    end else if (state_r == S_PH) begin
      mem[idx_r] <= rd_r + step_r;
    end
    if (state_r == S_RD) rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      trig_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (trig_done) trig_busy_r <= 1'b0;
      else if (trig_start) trig_busy_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            step_r <= q_data.step;
            if (q_data.func == eog_pkg::FUNC_LOAD) begin
              if (cnt_r < CW'(MAX_NODES)) cnt_r <= cnt_r + 1'b1;
            end else if (cnt_r != '0) begin
              idx_r <= IW'(cnt_r - 1'b1);
              state_r <= S_TCOS;
            end
          end
        end
        S_TCOS: if (trig_done) begin cphi_r <= trig_res; state_r <= S_TSIN; end
        S_TSIN: if (trig_done) begin sphi_r <= trig_res; state_r <= S_RD; end
        S_RD: state_r <= S_PH;
        S_PH: begin ph_r <= rd_r + step_r; state_r <= S_NCOS; end
        S_NCOS: if (trig_done) begin ct_r <= trig_res; state_r <= S_NSIN; end
        S_NSIN: if (trig_done) begin st_r <= trig_res; state_r <= S_M1; end
        S_M1: begin
          f_r[0] <= ct_r * cphi_r;
          f_r[1] <= st_r * sphi_r;
          f_r[2] <= ct_r * sphi_r;
          f_r[3] <= st_r * cphi_r;
          mi_r <= 2'd0;
          acc_x_r <= '0;
          acc_z_r <= '0;
          state_r <= S_M2;
        end
        S_M2: begin
          mprod_r <= mul_a * mul_b;
          state_r <= S_M3;
        end
        S_M3: begin
          unique case (mi_r)
            2'd0: acc_x_r <= acc_x_r + mprod_r;
            2'd1: acc_x_r <= acc_x_r - mprod_r;
            default: acc_z_r <= acc_z_r + mprod_r;
          endcase
          mi_r <= mi_r + 2'd1;
          state_r <= (mi_r == 2'd3) ? S_M4 : S_M2;
        end
        S_M4: begin
          if (out_load) begin
            out_r.node_index <= 6'(idx_r);
            out_r.pos_x <= (sx > 35'sd2147483647) ? 32'sh7fffffff :
                           (sx < -35'sd2147483648) ? 32'sh80000000 : sx[31:0];
            out_r.pos_z <= (sz > 35'sd2147483647) ? 32'sh7fffffff :
                           (sz < -35'sd2147483648) ? 32'sh80000000 : sz[31:0];
            out_r.spin_angle <= cfg.spin_base - ph_r;
            out_r.spin_valid <= cfg.spin_enable;
            out_r.last <= (idx_r == '0);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (idx_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r - 1'b1;
            state_r <= S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("result dropped under stall");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_NODES)) else $error("node count overflow");
  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    trig_start |-> !trig_busy_r) else $error("trig restarted while busy");
endmodule
`default_nettype wire

// ===== design/elliptical_orbit_generator_unit.sv =====
`default_nettype none
// elliptical orbit generator
// in channel: one beat per item; func load appends a node phase while under MAX_NODES,
//   func tick scales time_delta by speed and advances every stored phase
// out channel: one beat per stored node on a tick, highest node first,
//   last set on node 0; loads and ticks with no nodes give no beat
// cfg port: apb-style, register i at byte address 4*i, pready always high
// front end computes the phase step and feeds a two-entry command queue;
//   the back end walks nodes one at a time
// a tick first evaluates cosine and sine of the tilt; each node then takes two
//   sine evaluations on the shared sequential sine unit and four multiplies
// loads are stored in the back end without leaving its idle state
// reset: nodes cleared to zero count, registers to their reset values;
//   no clearing pass
// receiver stall: result held in the output register; the walk waits, the
//   queue still takes up to two items
module elliptical_orbit_generator_unit #(
  parameter int unsigned MAX_NODES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire eog_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output eog_pkg::out_beat_t      out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  eog_pkg::cfg_t cfg_r;
  logic          q_valid, q_ready;
  eog_pkg::cmd_t q_data;
  logic          wr;
  logic [2:0]    ra;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ra = cfg_paddr[4:2];

  // register writes; low address bits ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x    <= '0;
      cfg_r.center_z    <= '0;
      cfg_r.semi_major  <= 31'd65536;
      cfg_r.semi_minor  <= 31'd65536;
      cfg_r.tilt        <= '0;
      cfg_r.speed       <= 24'sd65536;
      cfg_r.spin_base   <= '0;
      cfg_r.spin_enable <= 1'b0;
    end else if (wr) begin
      unique case (ra)
        eog_pkg::REG_CENTER_X:    cfg_r.center_x    <= cfg_pwdata;
        eog_pkg::REG_CENTER_Z:    cfg_r.center_z    <= cfg_pwdata;
        eog_pkg::REG_SEMI_MAJOR:  cfg_r.semi_major  <= cfg_pwdata[30:0];
        eog_pkg::REG_SEMI_MINOR:  cfg_r.semi_minor  <= cfg_pwdata[30:0];
        eog_pkg::REG_TILT:        cfg_r.tilt        <= cfg_pwdata[15:0];
        eog_pkg::REG_SPEED:       cfg_r.speed       <= cfg_pwdata[23:0];
        eog_pkg::REG_SPIN_BASE:   cfg_r.spin_base   <= cfg_pwdata[15:0];
        default:                  cfg_r.spin_enable <= cfg_pwdata[0];
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (ra)
      eog_pkg::REG_CENTER_X:   cfg_prdata = cfg_r.center_x;
      eog_pkg::REG_CENTER_Z:   cfg_prdata = cfg_r.center_z;
      eog_pkg::REG_SEMI_MAJOR: cfg_prdata = {1'b0, cfg_r.semi_major};
      eog_pkg::REG_SEMI_MINOR: cfg_prdata = {1'b0, cfg_r.semi_minor};
      eog_pkg::REG_TILT:       cfg_prdata = {16'd0, cfg_r.tilt};
      eog_pkg::REG_SPEED:      cfg_prdata = {8'd0, cfg_r.speed};
      eog_pkg::REG_SPIN_BASE:  cfg_prdata = {16'd0, cfg_r.spin_base};
      default:                 cfg_prdata = {31'd0, cfg_r.spin_enable};
    endcase
  end

  eog_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .speed(cfg_r.speed),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  eog_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_data(q_data), .cfg(cfg_r), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  // tracks node phases and registers, predicts every orbit point
  class orbit_tracker;
    eog_pkg::out_beat_t pending_points[$];
    int        errors;
    logic [15:0] phase[16];
    int          loaded;
    longint      cx, cz, semi_a, semi_b, spd;
    logic [15:0] tilt_ang, spin_base;
    logic        spin_en;

    function new();
      errors = 0;
      loaded = 0;
      cx = 0;
      cz = 0;
      semi_a = 65536;
      semi_b = 65536;
      spd = 65536;
      tilt_ang = 0;
      spin_base = 0;
      spin_en = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        eog_pkg::REG_CENTER_X:    cx = longint'($signed(val));
        eog_pkg::REG_CENTER_Z:    cz = longint'($signed(val));
        eog_pkg::REG_SEMI_MAJOR:  semi_a = longint'(val[30:0]);
        eog_pkg::REG_SEMI_MINOR:  semi_b = longint'(val[30:0]);
        eog_pkg::REG_TILT:        tilt_ang = val[15:0];
        eog_pkg::REG_SPEED:       spd = longint'($signed(val[23:0]));
        eog_pkg::REG_SPIN_BASE:   spin_base = val[15:0];
        eog_pkg::REG_SPIN_ENABLE: spin_en = val[0];
        default: ;
      endcase
    endfunction

    // q14 quadrant position in, q15 out
    function longint quad_sine(longint x);
      longint z2, t, y;
      z2 = (x * x) >> 14;
      t = (2320 * z2) >> 14;
      t = 21024 - t;
      t = (t * z2) >> 14;
      t = 51472 - t;
      y = (x * t + 8192) >> 14;
      if (y > 32767) y = 32767;
      return y;
    endfunction

    function longint sine(logic [15:0] p);
      longint s;
      s = p[14] ? quad_sine(16384 - longint'(p[13:0])) : quad_sine(longint'(p[13:0]));
      return p[15] ? -s : s;
    endfunction

    function longint cosine(logic [15:0] p);
      return sine(p + 16'd16384);
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void take_beat(eog_pkg::in_beat_t b);
      longint prod, cp, sp, ct, st, vx, vz;
      logic [15:0] step;
      eog_pkg::out_beat_t o;
      if (b.func == eog_pkg::FUNC_LOAD) begin
        if (loaded < 16) begin
          phase[loaded] = b.phase_value;
          loaded++;
        end
        return;
      end
      prod = spd * longint'(b.time_delta) + 32768;
      step = prod[31:16];
      cp = cosine(tilt_ang);
      sp = sine(tilt_ang);
      for (int i = loaded - 1; i >= 0; i--) begin
        phase[i] = phase[i] + step;
        ct = cosine(phase[i]);
        st = sine(phase[i]);
        vx = semi_a * (ct * cp) - semi_b * (st * sp);
        vz = semi_a * (ct * sp) + semi_b * (st * cp);
        o.node_index = i[5:0];
        o.pos_x = clamp32(cx + ((vx + 64'sd536870912) >>> 30));
        o.pos_z = clamp32(cz + ((vz + 64'sd536870912) >>> 30));
        o.spin_angle = spin_base - phase[i];
        o.spin_valid = spin_en;
        o.last = (i == 0);
        pending_points.insert(pending_points.size(), o);
      end
    endfunction

    function void check_point(eog_pkg::out_beat_t got);
      eog_pkg::out_beat_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected beat, exp none got %h", $time, got);
        errors++;
        return;
      end
      want = pending_points.pop_front();
      if (got.node_index !== want.node_index)
        $display("%0t: node_index exp %0d got %0d", $time, want.node_index, got.node_index);
      if (got.pos_x !== want.pos_x)
        $display("%0t: pos_x exp %h got %h", $time, want.pos_x, got.pos_x);
      if (got.pos_z !== want.pos_z)
        $display("%0t: pos_z exp %h got %h", $time, want.pos_z, got.pos_z);
      if (got.spin_angle !== want.spin_angle)
        $display("%0t: spin_angle exp %h got %h", $time, want.spin_angle, got.spin_angle);
      if (got.spin_valid !== want.spin_valid)
        $display("%0t: spin_valid exp %b got %b", $time, want.spin_valid, got.spin_valid);
      if (got.last !== want.last)
        $display("%0t: last exp %b got %b", $time, want.last, got.last);
      if (got !== want) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  eog_pkg::in_beat_t  in_data;
  logic        out_valid;
  logic        out_ready;
  eog_pkg::out_beat_t out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  orbit_tracker tracker;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycles = 0;

  elliptical_orbit_generator_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver side: random stalls, checks every accepted result beat
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) tracker.check_point(out_data);
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // setup beat, then access beat; register written on the access edge
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  // valid stays high across back-to-back beats, dropped only for a gap
  task automatic send_beat(eog_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_beat(b);
  endtask

  task automatic send_op(logic f, logic [15:0] pv, logic [15:0] td);
    eog_pkg::in_beat_t b;
    b.func = f;
    b.phase_value = pv;
    b.time_delta = td;
    send_beat(b);
  endtask

  // drain results, then give the back end time to finish silent work
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_points.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    tracker = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tick with no nodes, phase extremes, tick lengths, overfill
    send_op(eog_pkg::FUNC_TICK, 16'h0000, 16'h1234);
    send_op(eog_pkg::FUNC_LOAD, 16'h0000, 16'hffff);
    send_op(eog_pkg::FUNC_TICK, 16'hffff, 16'h0000);
    send_op(eog_pkg::FUNC_LOAD, 16'hffff, 16'h0000);
    send_op(eog_pkg::FUNC_LOAD, 16'h4000, 16'h0000);
    send_op(eog_pkg::FUNC_TICK, 16'h0000, 16'hffff);
    send_op(eog_pkg::FUNC_LOAD, 16'h8000, 16'h0000);
    send_op(eog_pkg::FUNC_LOAD, 16'hc000, 16'h0000);
    send_op(eog_pkg::FUNC_TICK, 16'h5555, 16'h8000);
    for (int i = 0; i < 13; i++) send_op(eog_pkg::FUNC_LOAD, 16'(i * 4999), 16'(i));
    send_op(eog_pkg::FUNC_TICK, 16'haaaa, 16'h0001);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // extreme settings first, then random ones
      case (ph)
        0: begin
          write_reg(eog_pkg::REG_CENTER_X, 32'h7fffffff);
          write_reg(eog_pkg::REG_CENTER_Z, 32'h80000000);
          write_reg(eog_pkg::REG_SEMI_MAJOR, 32'h7fffffff);
          write_reg(eog_pkg::REG_SEMI_MINOR, 32'h0);
          write_reg(eog_pkg::REG_TILT, 32'h4000);
          write_reg(eog_pkg::REG_SPEED, 32'h7fffff);
          write_reg(eog_pkg::REG_SPIN_BASE, 32'hffff);
          write_reg(eog_pkg::REG_SPIN_ENABLE, 32'h1);
        end
        1: begin
          write_reg(eog_pkg::REG_CENTER_X, 32'h80000000);
          write_reg(eog_pkg::REG_CENTER_Z, 32'h7fffffff);
          write_reg(eog_pkg::REG_SEMI_MAJOR, 32'h0);
          write_reg(eog_pkg::REG_SEMI_MINOR, 32'hffffffff);
          write_reg(eog_pkg::REG_TILT, 32'hffff);
          write_reg(eog_pkg::REG_SPEED, 32'h800000);
          write_reg(eog_pkg::REG_SPIN_BASE, 32'h0);
          write_reg(eog_pkg::REG_SPIN_ENABLE, 32'h0);
        end
        default: begin
          write_reg(eog_pkg::REG_CENTER_X, $urandom);
          write_reg(eog_pkg::REG_CENTER_Z, $urandom);
          write_reg(eog_pkg::REG_SEMI_MAJOR, $urandom >> ($urandom_range(12)));
          write_reg(eog_pkg::REG_SEMI_MINOR, $urandom >> ($urandom_range(12)));
          write_reg(eog_pkg::REG_TILT, $urandom);
          write_reg(eog_pkg::REG_SPEED, $urandom);
          write_reg(eog_pkg::REG_SPIN_BASE, $urandom);
          write_reg(eog_pkg::REG_SPIN_ENABLE, $urandom);
        end
      endcase
      for (int n = 0; n < 55; n++) begin
        // mostly ticks; loads here hit a full node table
        if ($urandom_range(99) < 15)
          send_op(eog_pkg::FUNC_LOAD, 16'($urandom), 16'($urandom));
        else if ($urandom_range(1))
          send_op(eog_pkg::FUNC_TICK, 16'($urandom), 16'($urandom));
        else
          send_op(eog_pkg::FUNC_TICK, 16'($urandom), 16'($urandom_range(64)));
      end
      settle();
    end

    if (tracker.errors == 0 && tracker.pending_points.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
